[src/fsts_pkg.sv]
// fsts_pkg: shared types and codes for the fixed-step tick scheduler.
// No dependencies; used by fixed_step_tick_scheduler.
package fsts_pkg;

    localparam int DELTA_W = 32;
    localparam int STEP_W  = 8;
    localparam int DROP_W  = 48;
    localparam int REM_W   = 32;
    localparam int CFG_W   = 32;

    localparam logic [1:0] MODE_ADVANCE = 2'd0;
    localparam logic [1:0] MODE_STEP    = 2'd1;
    localparam logic [1:0] MODE_PAUSE   = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    localparam logic [1:0] CFG_STEP_INTERVAL   = 2'd0;
    localparam logic [1:0] CFG_MAX_CATCH_UP    = 2'd1;
    localparam logic [1:0] CFG_MAX_FRAME_DELTA = 2'd2;

    localparam logic [STEP_W-1:0] CATCH_UP_RESET = 8'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FDROP,
        ST_DIV,
        ST_GRANT,
        ST_MUL,
        ST_SUB,
        ST_CDROP,
        ST_FINISH
    } state_t;

endpackage

[src/fsts_div.sv]
// fsts_div: restoring divider, one quotient bit per cycle.
// Divides a W+1 bit dividend by a nonzero W bit divisor. No dependencies.
module fsts_div #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W:0]   dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W:0]   quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 2);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  div_reg, div_next;
    logic [W:0]    trial;
    logic          fits;

    always_comb begin
        trial = {rem_reg, quo_reg[W]};
        fits  = trial >= {1'b0, div_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W + 1);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[W-1:0], fits};
            rem_next = fits ? W'(trial - {1'b0, div_reg}) : trial[W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && div_reg != '0) |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

[src/fixed_step_tick_scheduler.sv]
// fixed_step_tick_scheduler: fixed timestep accumulator with catch-up limit.
// Depends on fsts_pkg and fsts_div.
//
// Usage:
//   Commands enter on the s_ channel (valid/ready); one result per command
//   leaves on the m_ channel (valid/ready). Registers are written through
//   cfg_wen/cfg_index/cfg_wdata, one write per cycle. The user must write them
//   only while idle; the block itself does not enforce this. An advance
//   command while running with a nonzero step interval passes through a
//   saturating add of the frame drop, the bit-serial divider (one quotient
//   bit per cycle), then the grant, multiply, subtract and saturating-add
//   steps. Every other command goes straight to the finish step. s_ready
//   rises together with m_valid, so the next command waits for the result.
//   The result sits in an output register; the next command is taken while
//   it waits. If the receiver stalls, the following result holds in the
//   sequencer until the output register frees, and no new command is taken.
//   Reset (aresetn low, synchronous) clears the accumulator, dropped total,
//   pause and pending flags, sets step_interval = 0, max_catch_up = 8 and
//   max_frame_delta = 0, and empties the output register.
module fixed_step_tick_scheduler #(
    parameter int TIME_BITS = 32,
    parameter int DROP_BITS = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [1:0]                    cfg_index,
    input  logic [fsts_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [fsts_pkg::DELTA_W-1:0]  s_wall_delta,
    input  logic                          s_pause_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fsts_pkg::STEP_W-1:0]   m_step_count,
    output logic [fsts_pkg::DROP_W-1:0]   m_dropped_total,
    output logic [fsts_pkg::REM_W-1:0]    m_remainder
);

    localparam int TW = TIME_BITS;
    localparam int PW = TIME_BITS + fsts_pkg::STEP_W;
    localparam int SW = ((DROP_BITS > TIME_BITS + 1) ? DROP_BITS : TIME_BITS + 1) + 1;

    fsts_pkg::state_t state_reg, state_next;

    logic [TW-1:0]                   interval_reg, interval_next;
    logic [fsts_pkg::STEP_W-1:0]     catch_reg, catch_next;
    logic [TW-1:0]                   frame_reg, frame_next;
    logic [TW-1:0]                   acc_reg, acc_next;
    logic [DROP_BITS-1:0]            drop_reg, drop_next;
    logic                            paused_reg, paused_next;
    logic                            pend_reg, pend_next;
    logic                            m_valid_reg, m_valid_next;

    logic [1:0]                      mode_reg, mode_next;
    logic [TW-1:0]                   delta_reg, delta_next;
    logic                            level_reg, level_next;
    logic [TW:0]                     sum_reg, sum_next;
    logic [TW:0]                     amt_reg, amt_next;
    logic [TW:0]                     base_reg, base_next;
    logic [PW-1:0]                   prod_reg, prod_next;
    logic [fsts_pkg::STEP_W-1:0]     steps_reg, steps_next;
    logic [fsts_pkg::STEP_W-1:0]     out_steps_reg, out_steps_next;
    logic [fsts_pkg::DROP_W-1:0]     out_drop_reg, out_drop_next;
    logic [fsts_pkg::REM_W-1:0]      out_rem_reg, out_rem_next;

    logic                            out_free;
    logic [TW:0]                     sum_calc;
    logic [SW-1:0]                   sat_sum;
    logic [DROP_BITS-1:0]            drop_sat;
    logic [fsts_pkg::STEP_W-1:0]     limit;
    logic                            div_start;
    logic                            div_done;
    logic [TW:0]                     div_quo;
    logic [TW-1:0]                   div_rem;

    fsts_div #(.W(TW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (sum_calc),
        .divisor   (interval_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        sum_calc = {1'b0, acc_reg} + {1'b0, delta_reg};
        sat_sum  = SW'(drop_reg) + SW'(amt_reg);
        drop_sat = (sat_sum > SW'({DROP_BITS{1'b1}})) ? {DROP_BITS{1'b1}}
                                                      : sat_sum[DROP_BITS-1:0];
        limit    = (catch_reg == '0) ? fsts_pkg::STEP_W'(1) : catch_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fsts_pkg::ST_IDLE: begin
                if (s_valid) state_next = fsts_pkg::ST_EXEC;
            end
            fsts_pkg::ST_EXEC: begin
                if (mode_reg == fsts_pkg::MODE_ADVANCE && !paused_reg && interval_reg != '0)
                    state_next = fsts_pkg::ST_FDROP;
                else
                    state_next = fsts_pkg::ST_FINISH;
            end
            fsts_pkg::ST_FDROP: state_next = fsts_pkg::ST_DIV;
            fsts_pkg::ST_DIV: begin
                if (div_done) state_next = fsts_pkg::ST_GRANT;
            end
            fsts_pkg::ST_GRANT: state_next = fsts_pkg::ST_MUL;
            fsts_pkg::ST_MUL:   state_next = fsts_pkg::ST_SUB;
            fsts_pkg::ST_SUB:   state_next = fsts_pkg::ST_CDROP;
            fsts_pkg::ST_CDROP: state_next = fsts_pkg::ST_FINISH;
            fsts_pkg::ST_FINISH: begin
                if (out_free) state_next = fsts_pkg::ST_IDLE;
            end
            default: state_next = fsts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        interval_next  = interval_reg;
        catch_next     = catch_reg;
        frame_next     = frame_reg;
        acc_next       = acc_reg;
        drop_next      = drop_reg;
        paused_next    = paused_reg;
        pend_next      = pend_reg;
        m_valid_next   = m_valid_reg;
        mode_next      = mode_reg;
        delta_next     = delta_reg;
        level_next     = level_reg;
        sum_next       = sum_reg;
        amt_next       = amt_reg;
        base_next      = base_reg;
        prod_next      = prod_reg;
        steps_next     = steps_reg;
        out_steps_next = out_steps_reg;
        out_drop_next  = out_drop_reg;
        out_rem_next   = out_rem_reg;
        div_start      = 1'b0;

        if (m_ready) m_valid_next = 1'b0;

        case (state_reg)
            fsts_pkg::ST_IDLE: begin
                mode_next  = s_mode;
                delta_next = TW'(s_wall_delta);
                level_next = s_pause_level;
            end
            fsts_pkg::ST_EXEC: begin
                steps_next = '0;
                amt_next   = '0;
                case (mode_reg)
                    fsts_pkg::MODE_ADVANCE: begin
                        if (paused_reg) begin
                            acc_next = '0;
                            if (pend_reg && interval_reg != '0) begin
                                steps_next = fsts_pkg::STEP_W'(1);
                                pend_next  = 1'b0;
                            end
                        end else if (frame_reg != '0 && delta_reg > frame_reg) begin
                            amt_next   = {1'b0, delta_reg - frame_reg};
                            delta_next = frame_reg;
                        end
                    end
                    fsts_pkg::MODE_STEP: begin
                        if (paused_reg) pend_next = 1'b1;
                    end
                    fsts_pkg::MODE_PAUSE: begin
                        if (paused_reg != level_reg) begin
                            paused_next = level_reg;
                            acc_next    = '0;
                            pend_next   = 1'b0;
                        end
                    end
                    fsts_pkg::MODE_CLEAR: begin
                        acc_next  = '0;
                        drop_next = '0;
                        pend_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            fsts_pkg::ST_FDROP: begin
                drop_next = drop_sat;
                sum_next  = sum_calc;
                div_start = 1'b1;
            end
            fsts_pkg::ST_DIV: begin
                if (div_done) acc_next = div_rem;
            end
            fsts_pkg::ST_GRANT: begin
                steps_next = (div_quo < (TW+1)'(limit)) ? div_quo[fsts_pkg::STEP_W-1:0]
                                                         : limit;
            end
            fsts_pkg::ST_MUL: begin
                prod_next = PW'(steps_reg) * PW'(interval_reg);
                base_next = sum_reg - {1'b0, acc_reg};
            end
            fsts_pkg::ST_SUB: begin
                amt_next = (TW+1)'(PW'(base_reg) - prod_reg);
            end
            fsts_pkg::ST_CDROP: begin
                drop_next = drop_sat;
            end
            fsts_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_steps_next = steps_reg;
                    out_drop_next  = fsts_pkg::DROP_W'(drop_reg);
                    out_rem_next   = fsts_pkg::REM_W'(acc_reg);
                end
            end
            default: begin
            end
        endcase

        if (cfg_wen) begin
            case (cfg_index)
                fsts_pkg::CFG_STEP_INTERVAL: begin
                    interval_next = TW'(cfg_wdata);
                    acc_next      = '0;
                    pend_next     = 1'b0;
                end
                fsts_pkg::CFG_MAX_CATCH_UP:    catch_next = cfg_wdata[fsts_pkg::STEP_W-1:0];
                fsts_pkg::CFG_MAX_FRAME_DELTA: frame_next = TW'(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fsts_pkg::ST_IDLE;
            interval_reg <= '0;
            catch_reg    <= fsts_pkg::CATCH_UP_RESET;
            frame_reg    <= '0;
            acc_reg      <= '0;
            drop_reg     <= '0;
            paused_reg   <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            interval_reg <= interval_next;
            catch_reg    <= catch_next;
            frame_reg    <= frame_next;
            acc_reg      <= acc_next;
            drop_reg     <= drop_next;
            paused_reg   <= paused_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        delta_reg     <= delta_next;
        level_reg     <= level_next;
        sum_reg       <= sum_next;
        amt_reg       <= amt_next;
        base_reg      <= base_next;
        prod_reg      <= prod_next;
        steps_reg     <= steps_next;
        out_steps_reg <= out_steps_next;
        out_drop_reg  <= out_drop_next;
        out_rem_reg   <= out_rem_next;
    end

    assign s_ready         = (state_reg == fsts_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_step_count    = out_steps_reg;
    assign m_dropped_total = out_drop_reg;
    assign m_remainder     = out_rem_reg;

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice without processing");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == fsts_pkg::ST_FINISH))
        else $error("result loaded outside finish state");

    a_pending_only_paused: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> paused_reg)
        else $error("single step pending while running");

endmodule
